/* hdl/gsig_pkg.sv */
// Shared widths, constants, types and the corner pattern for the grid skirt index generator.
package gsig_pkg;

	localparam int IDX_W = 13;
	localparam int CFG_W = 7;
	localparam int COORD_W = 6;
	localparam int DATA_IN_W = 16;
	localparam int DATA_OUT_W = 16;
	localparam int MAX_QUADS_DEF = 64;
	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;
	localparam int QUAD_LEN = 12;
	localparam int GRID_LEN = 6;
	localparam int POS_W = 4;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [1:0] corner_t;

	localparam corner_t CRN_A = 2'd0;
	localparam corner_t CRN_B = 2'd1;
	localparam corner_t CRN_C = 2'd2;
	localparam corner_t CRN_D = 2'd3;

	localparam logic ACT_GRID = 1'b0;
	localparam logic ACT_SKIRT = 1'b1;

	// Corner order of one double-sided quad: a b c, a c d, a c b, a d c.
	function automatic corner_t quad_corner(input logic [POS_W-1:0] pos);
		corner_t c;
		case (pos)
			4'd0: c = CRN_A;
			4'd1: c = CRN_B;
			4'd2: c = CRN_C;
			4'd3: c = CRN_A;
			4'd4: c = CRN_C;
			4'd5: c = CRN_D;
			4'd6: c = CRN_A;
			4'd7: c = CRN_C;
			4'd8: c = CRN_B;
			4'd9: c = CRN_A;
			4'd10: c = CRN_D;
			4'd11: c = CRN_C;
			default: c = CRN_A;
		endcase
		return c;
	endfunction

endpackage

/* hdl/grid_skirt_index_generator.sv */
// Top level of the grid skirt index generator: input pipeline, index emitter and output register.
//
// Usage: each item on the s_ channel is one grid cell (s_tuser = 0, cell_x and cell_z in
// s_tdata) or one skirt step (s_tuser = 1, step number in cell_x). The m_ channel returns
// one vertex index per transfer in m_tdata, with m_tlast on the final index of each input
// item and m_tuser set when the cell lies outside the grid; such an item gives a single
// index of zero. A grid cell gives six indices, a skirt step 48.
// The quad count per side is written on the cfg_ channel while the block is idle; values
// above MAX_QUADS saturate. cfg_ready is always high.
// Pipeline: an accepted item passes the stage registers s1 to s4, the emitter and the output
// register in that order. Four arithmetic stages feed an emitter that drives the output
// register at one index per cycle while m_tready is high, so throughput is set by the single
// output port: six indices per grid cell, 48 per skirt step and one per bad cell.
// Reset clears all valid bits and loads the quad count with 64; no item is in flight.
// When the receiver holds m_tready low, the output register and emitter hold, the
// stages behind them fill, and s_tready falls once all of them are occupied.
module grid_skirt_index_generator #(
	parameter int MAX_QUADS = gsig_pkg::MAX_QUADS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [gsig_pkg::CFG_W-1:0] cfg_data,
	input logic s_tvalid,
	output logic s_tready,
	input logic [gsig_pkg::DATA_IN_W-1:0] s_tdata, // cell_x [5:0], cell_z [11:6]
	input logic s_tuser, // action
	output logic m_tvalid,
	input logic m_tready,
	output logic [gsig_pkg::DATA_OUT_W-1:0] m_tdata, // vertex_index [12:0]
	output logic m_tlast,
	output logic m_tuser // bad_cell
);
	import gsig_pkg::*;

	localparam int QW = ($clog2(MAX_QUADS + 1) > CFG_W) ? $clog2(MAX_QUADS + 1) : CFG_W;
	localparam logic [QW-1:0] MAX_Q = QW'(MAX_QUADS);

	logic [CFG_W-1:0] cfg_q;
	logic [QW-1:0] q_eff;
	logic [COORD_W-1:0] in_x;
	logic [COORD_W-1:0] in_z;
	logic in_bad;

	logic v_s1, v_s2, v_s3, v_s4;
	logic s1_ready, s2_ready, s3_ready, s4_ready;

	logic act_s1, bad_s1;
	logic [COORD_W-1:0] x_s1, z_s1;
	logic [QW-1:0] q_s1;

	logic act_s2, bad_s2;
	idx_t x_s2, q_s2, v_s2_val, v2_s2, v3_s2, zv_s2, xv_s2, qv_s2, vv_s2;

	logic act_s3, bad_s3;
	idx_t a_s3 [4];
	idx_t d_s3 [4];
	idx_t boff_s3 [4];
	idx_t coff_s3 [4];

	logic act_s4, bad_s4;
	idx_t crn_s4 [16];

	idx_t crn_q [16];
	logic act_q, bad_q, busy_q;
	logic [1:0] quad_q;
	logic [POS_W-1:0] pos_q;

	logic m_tvalid_q;
	idx_t index_q;
	logic last_q, badout_q;

	logic out_load, emit, emit_ready, is_last;
	idx_t emit_index;
	idx_t v1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid) begin
			cfg_q <= cfg_data;
		end
	end

	assign q_eff = (QW'(cfg_q) > MAX_Q) ? MAX_Q : QW'(cfg_q);
	assign in_x = s_tdata[COORD_W-1:0];
	assign in_z = s_tdata[2*COORD_W-1:COORD_W];
	assign in_bad = (QW'(in_x) >= q_eff) || ((s_tuser == ACT_GRID) && (QW'(in_z) >= q_eff));

	// Handshake chain: a stage takes new data when it is empty or its content moves on.
	assign out_load = !m_tvalid_q || m_tready;
	assign emit = busy_q && out_load;
	assign is_last = bad_q
		|| ((act_q == ACT_GRID) && (pos_q == POS_W'(GRID_LEN - 1)))
		|| ((act_q == ACT_SKIRT) && (quad_q == 2'd3) && (pos_q == POS_W'(QUAD_LEN - 1)));
	assign emit_ready = !busy_q || (emit && is_last);
	assign s4_ready = !v_s4 || emit_ready;
	assign s3_ready = !v_s3 || s4_ready;
	assign s2_ready = !v_s2 || s3_ready;
	assign s1_ready = !v_s1 || s2_ready;
	assign s_tready = s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (s1_ready) begin
				v_s1 <= s_tvalid;
			end
			if (s2_ready) begin
				v_s2 <= v_s1;
			end
			if (s3_ready) begin
				v_s3 <= v_s2;
			end
			if (s4_ready) begin
				v_s4 <= v_s3;
			end
		end
	end

	assign v1 = IDX_W'(1);

	always_ff @(posedge clk) begin
		if (s1_ready && s_tvalid) begin
			act_s1 <= s_tuser;
			x_s1 <= in_x;
			z_s1 <= in_z;
			q_s1 <= q_eff;
			bad_s1 <= in_bad;
		end
		if (s2_ready && v_s1) begin
			act_s2 <= act_s1;
			bad_s2 <= bad_s1;
			x_s2 <= IDX_W'(x_s1);
			q_s2 <= IDX_W'(q_s1);
			v_s2_val <= IDX_W'(q_s1) + v1;
			v2_s2 <= IDX_W'(q_s1) + IDX_W'(q_s1) + IDX_W'(2);
			v3_s2 <= IDX_W'(q_s1) + IDX_W'(q_s1) + IDX_W'(q_s1) + IDX_W'(3);
			zv_s2 <= IDX_W'(z_s1) * (IDX_W'(q_s1) + v1);
			xv_s2 <= IDX_W'(x_s1) * (IDX_W'(q_s1) + v1);
			qv_s2 <= IDX_W'(q_s1) * (IDX_W'(q_s1) + v1);
			vv_s2 <= (IDX_W'(q_s1) + v1) * (IDX_W'(q_s1) + v1);
		end
		if (s3_ready && v_s2) begin
			act_s3 <= act_s2;
			bad_s3 <= bad_s2;
			if (act_s2 == ACT_GRID) begin
				a_s3[0] <= zv_s2 + x_s2;
				d_s3[0] <= zv_s2 + x_s2 + v1;
				boff_s3[0] <= v_s2_val;
				coff_s3[0] <= v_s2_val;
			end else begin
				a_s3[0] <= x_s2;
				d_s3[0] <= vv_s2 + x_s2;
				boff_s3[0] <= v1;
				coff_s3[0] <= v1;
			end
			a_s3[1] <= qv_s2 + x_s2;
			d_s3[1] <= vv_s2 + v_s2_val + x_s2;
			boff_s3[1] <= v1;
			coff_s3[1] <= v1;
			a_s3[2] <= xv_s2;
			d_s3[2] <= vv_s2 + v2_s2 + x_s2;
			boff_s3[2] <= v_s2_val;
			coff_s3[2] <= v1;
			a_s3[3] <= xv_s2 + q_s2;
			d_s3[3] <= vv_s2 + v3_s2 + x_s2;
			boff_s3[3] <= v_s2_val;
			coff_s3[3] <= v1;
		end
		if (s4_ready && v_s3) begin
			act_s4 <= act_s3;
			bad_s4 <= bad_s3;
			for (int k = 0; k < 4; k++) begin
				crn_s4[4*k + 0] <= a_s3[k];
				crn_s4[4*k + 1] <= a_s3[k] + boff_s3[k];
				crn_s4[4*k + 2] <= d_s3[k] + coff_s3[k];
				crn_s4[4*k + 3] <= d_s3[k];
			end
		end
		if (emit_ready && v_s4) begin
			act_q <= act_s4;
			bad_q <= bad_s4;
			crn_q <= crn_s4;
		end
		if (emit) begin
			index_q <= emit_index;
			last_q <= is_last;
			badout_q <= bad_q;
		end
	end

	assign emit_index = bad_q ? '0 : crn_q[{quad_q, quad_corner(pos_q)}];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			quad_q <= 2'd0;
			pos_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= busy_q;
			end
			if (emit_ready && v_s4) begin
				busy_q <= 1'b1;
				pos_q <= '0;
				quad_q <= 2'd0;
			end else if (emit) begin
				if (is_last) begin
					busy_q <= 1'b0;
				end else if (pos_q == POS_W'(QUAD_LEN - 1)) begin
					pos_q <= '0;
					quad_q <= quad_q + 2'd1;
				end else begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = DATA_OUT_W'(index_q);
	assign m_tlast = last_q;
	assign m_tuser = badout_q;

	a_bad_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0))
		else $error("Flagged cell result is not a single zero index.");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pos_q < POS_W'(QUAD_LEN)))
		else $error("Emitter position out of range.");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && m_tvalid && !m_tready |=> $stable(pos_q) && $stable(quad_q) && busy_q)
		else $error("Emitter advanced while the output was stalled.");

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> v_s1 && v_s2 && v_s3 && v_s4 && busy_q)
		else $error("Input stalled with a free pipeline stage.");

	a_grid_last: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !bad_q && (act_q == ACT_GRID) |-> (quad_q == 2'd0))
		else $error("Grid cell emitted beyond its first quad.");

endmodule

/* tb/tb_grid_skirt_index_generator.sv */
// Self-checking testbench for the grid skirt index generator with its own index predictor.
`timescale 1ns / 100ps

module tb_grid_skirt_index_generator;
	import gsig_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE = 8;

	typedef struct packed {
		idx_t index;
		logic last;
		logic bad;
	} index_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [DATA_IN_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b1;
	logic [DATA_OUT_W-1:0] m_tdata;
	logic m_tlast;
	logic m_tuser;

	index_result_t expected_indices[$];
	logic [CFG_W-1:0] quads_reg = CFG_RESET;
	int errors = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int gap_max = 0;
	logic rx_random = 1'b0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;
	int stall_left = 0;

	grid_skirt_index_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	always #10 clk = ~clk;

	function automatic int quads_eff();
		return (quads_reg > MAX_QUADS_DEF) ? MAX_QUADS_DEF : int'(quads_reg);
	endfunction

	function automatic void expect_result(input index_result_t r);
		expected_indices = {expected_indices, r};
	endfunction

	function automatic void predict_indices(input logic act, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] z);
		int q;
		int v;
		int n;
		int base;
		int s;
		int k;
		int idx[48];
		int crn[4][4];
		int order[12];
		index_result_t r;
		order = '{0, 1, 2, 0, 2, 3, 0, 2, 1, 0, 3, 2};
		q = quads_eff();
		v = q + 1;
		n = 0;
		if (x >= q || (act == ACT_GRID && z >= q)) begin
			r.index = '0;
			r.last = 1'b1;
			r.bad = 1'b1;
			expect_result(r);
			return;
		end
		if (act == ACT_GRID) begin
			base = z * v + x;
			idx[0] = base;
			idx[1] = base + v;
			idx[2] = base + v + 1;
			idx[3] = base;
			idx[4] = base + v + 1;
			idx[5] = base + 1;
			n = 6;
		end else begin
			base = v * v;
			crn[0] = '{x, x + 1, base + x + 1, base + x};
			crn[1] = '{q * v + x, q * v + x + 1, base + v + x + 1, base + v + x};
			crn[2] = '{x * v, x * v + v, base + 2 * v + x + 1, base + 2 * v + x};
			crn[3] = '{x * v + q, x * v + q + v, base + 3 * v + x + 1, base + 3 * v + x};
			for (s = 0; s < 4; s++) begin
				for (k = 0; k < 12; k++) begin
					idx[n] = crn[s][order[k]];
					n++;
				end
			end
		end
		for (k = 0; k < n; k++) begin
			r.index = idx_t'(idx[k]);
			r.last = (k == n - 1);
			r.bad = 1'b0;
			expect_result(r);
		end
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $time);
	endtask

	always @(posedge clk) begin
		index_result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				quads_reg = cfg_data;
			end
			if (m_tvalid && m_tready) begin
				if (expected_indices.size() == 0) begin
					report_mismatch("unexpected index", int'(m_tdata), -1);
				end else begin
					want = expected_indices.pop_front();
					if (m_tdata !== DATA_OUT_W'(want.index)) begin
						report_mismatch("vertex_index", int'(m_tdata), int'(want.index));
					end
					if (m_tlast !== want.last) begin
						report_mismatch("last_of_item", int'(m_tlast), int'(want.last));
					end
					if (m_tuser !== want.bad) begin
						report_mismatch("bad_cell", int'(m_tuser), int'(want.bad));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				predict_indices(s_tuser, s_tdata[COORD_W-1:0], s_tdata[2*COORD_W-1:COORD_W]);
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// The receiver stalls on its own pattern, plus one long hold per request.
	always @(negedge clk) begin
		if (hold_requests != holds_served) begin
			holds_served++;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (rx_random && $urandom_range(0, 99) < 20) begin
			stall_left = $urandom_range(0, 7);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_item(input logic act, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] z);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {{(DATA_IN_W - 2 * COORD_W){1'b0}}, z, x};
		s_tuser <= act;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_indices.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_quads(input logic [CFG_W-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_items(input int count);
		int q;
		logic act;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] z;
		repeat (count) begin
			q = quads_eff();
			act = ($urandom_range(0, 99) < 30) ? ACT_SKIRT : ACT_GRID;
			if (q > 0 && $urandom_range(0, 99) < 85) begin
				x = COORD_W'($urandom_range(0, q - 1));
				z = COORD_W'($urandom_range(0, q - 1));
			end else begin
				x = COORD_W'($urandom_range(0, 63));
				z = COORD_W'($urandom_range(0, 63));
			end
			send_item(act, x, z);
		end
	endtask

	task automatic test_reset_quads();
		rx_random = 1'b1;
		gap_max = 3;
		send_item(ACT_GRID, 6'd0, 6'd0);
		send_item(ACT_GRID, 6'd63, 6'd0);
		send_item(ACT_GRID, 6'd0, 6'd63);
		send_item(ACT_GRID, 6'd63, 6'd63);
		send_item(ACT_GRID, 6'd21, 6'd42);
		send_item(ACT_GRID, 6'd42, 6'd21);
		send_item(ACT_SKIRT, 6'd0, 6'd0);
		send_item(ACT_SKIRT, 6'd63, 6'd0);
		send_item(ACT_SKIRT, 6'd42, 6'd21);
		send_item(ACT_SKIRT, 6'd21, 6'd63);
	endtask

	task automatic test_single_quad();
		write_quads(7'd1);
		send_item(ACT_GRID, 6'd0, 6'd0);
		send_item(ACT_GRID, 6'd1, 6'd0);
		send_item(ACT_GRID, 6'd0, 6'd1);
		send_item(ACT_GRID, 6'd63, 6'd63);
		send_item(ACT_SKIRT, 6'd0, 6'd63);
		send_item(ACT_SKIRT, 6'd1, 6'd0);
	endtask

	task automatic test_zero_quads();
		write_quads(7'd0);
		send_item(ACT_GRID, 6'd0, 6'd0);
		send_item(ACT_SKIRT, 6'd0, 6'd0);
	endtask

	task automatic test_saturation();
		write_quads(7'd127);
		send_item(ACT_GRID, 6'd63, 6'd63);
		send_item(ACT_SKIRT, 6'd63, 6'd0);
		write_quads(7'd65);
		send_item(ACT_GRID, 6'd63, 6'd0);
		send_item(ACT_SKIRT, 6'd0, 6'd0);
	endtask

	task automatic test_random_phases();
		int phase_quads[7];
		phase_quads = '{37, 64, 2, 127, 0, 1, 64};
		phase_quads[4] = $urandom_range(3, 63);
		for (int p = 0; p < 7; p++) begin
			write_quads(phase_quads[p][CFG_W-1:0]);
			rx_random = p[0] ? 1'b0 : 1'b1;
			gap_max = p[0] ? 0 : 6;
			send_random_items(52);
		end
	endtask

	task automatic test_backpressure();
		write_quads(7'd8);
		rx_random = 1'b0;
		gap_max = 0;
		@(negedge clk);
		hold_requests++;
		send_random_items(40);
		drain_results();
		rx_random = 1'b1;
		gap_max = 4;
		send_random_items(30);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_quads();
		test_single_quad();
		test_zero_quads();
		test_saturation();
		test_random_phases();
		test_backpressure();
		drain_results();
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
